// ===== rtl/core/s2dh_pkg.sv =====
// Package for the saturating 2-D histogram: item structs, register map,
// controller states and the bin limit table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package s2dh_pkg;

	localparam int DEF_MAX_BINS_X = 256;
	localparam int DEF_MAX_BINS_Y = 256;
	localparam int DEF_COUNT_BITS = 32;

	localparam int CFG_ADDR_W = 5;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_BINS_X     = 3'd2;
	localparam logic [2:0] REG_BINS_Y     = 3'd3;
	localparam logic [2:0] REG_COUNT_MODE = 3'd4;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [1:0] MODE_FULL  = 2'd0;
	localparam logic [1:0] MODE_8BIT  = 2'd1;
	localparam logic [1:0] MODE_16BIT = 2'd2;
	localparam logic [1:0] MODE_32BIT = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RANGE,
		ST_ADDR,
		ST_READ,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] x_value;
		logic signed [31:0] y_value;
		logic        [15:0] read_index;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] bin_count;
		logic        counted;
		logic        out_of_range;
		logic        bin_full;
		logic [31:0] lost_total;
	} res_item_t;

	function automatic logic [31:0] mode_limit(input logic [1:0] mode);
		logic [31:0] lim;
		case (mode)
			MODE_FULL:  lim = 32'hFFFF_FFFF;
			MODE_8BIT:  lim = 32'd255;
			MODE_16BIT: lim = 32'd65535;
			MODE_32BIT: lim = 32'hFFFF_FFFF;
			default:    lim = 32'hFFFF_FFFF;
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/saturating_2d_histogram.sv =====
// Saturating 2-D histogram: bin store in one synchronous RAM, read-modify-write
// controller, APB register block. Depends on s2dh_pkg.
//
//   channel  dir  handshake           payload
//   cmd      in   cmd_valid/cmd_stall cmd (cmd_item_t)
//   res      out  res_valid/res_stall res (res_item_t)
//   apb      in   psel/penable/pready origin_x, origin_y, bins_x, bins_y, count_mode
//
// Each item passes through five steps: capture, range check, index multiply, RAM read,
// update/write-back; the read-modify-write on the synchronous RAM sets that sequence.
// After reset a clearing pass writes zero to all MAX_BINS_X*MAX_BINS_Y bins,
// one per cycle (65536 bins at default size); cmd_stall is high meanwhile.
// The result register holds a finished item while the next one is accepted;
// the update stage waits only if the result register is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module saturating_2d_histogram
	import s2dh_pkg::*;
#(
	parameter int MAX_BINS_X = DEF_MAX_BINS_X,
	parameter int MAX_BINS_Y = DEF_MAX_BINS_Y,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cmd_valid,
	output      logic                  cmd_stall,
	input  wire cmd_item_t             cmd,

	output      logic                  res_valid,
	input  wire logic                  res_stall,
	output      res_item_t             res,

	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output      logic [CFG_DATA_W-1:0] prdata,
	output      logic                  pready
);

	localparam int DEPTH = MAX_BINS_X * MAX_BINS_Y;
	localparam int XW    = (MAX_BINS_X > 1) ? $clog2(MAX_BINS_X) : 1;
	localparam int YW    = (MAX_BINS_Y > 1) ? $clog2(MAX_BINS_Y) : 1;
	localparam int NXW   = $clog2(MAX_BINS_X + 1);
	localparam int NYW   = $clog2(MAX_BINS_Y + 1);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = NXW + YW + 1;
	localparam int CB    = COUNT_BITS;

	// configuration registers
	logic signed [31:0] origin_x_q, origin_y_q;
	logic        [8:0]  bins_x_q, bins_y_q;
	logic        [1:0]  count_mode_q;
	logic               cfg_wr;
	logic        [2:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			bins_x_q     <= 9'd256;
			bins_y_q     <= 9'd256;
			count_mode_q <= MODE_FULL;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_ORIGIN_X:   origin_x_q   <= pwdata;
				REG_ORIGIN_Y:   origin_y_q   <= pwdata;
				REG_BINS_X:     bins_x_q     <= pwdata[8:0];
				REG_BINS_Y:     bins_y_q     <= pwdata[8:0];
				REG_COUNT_MODE: count_mode_q <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ORIGIN_X:   prdata = origin_x_q;
			REG_ORIGIN_Y:   prdata = origin_y_q;
			REG_BINS_X:     prdata = {23'd0, bins_x_q};
			REG_BINS_Y:     prdata = {23'd0, bins_y_q};
			REG_COUNT_MODE: prdata = {30'd0, count_mode_q};
			default:        prdata = '0;
		endcase
	end

	// effective grid size
	logic [31:0]    bx32, by32;
	logic [NXW-1:0] nx;
	logic [NYW-1:0] ny;

	always_comb begin
		if (bins_x_q == 9'd0) begin
			bx32 = 32'd1;
		end else if ({23'd0, bins_x_q} > 32'(MAX_BINS_X)) begin
			bx32 = 32'(MAX_BINS_X);
		end else begin
			bx32 = {23'd0, bins_x_q};
		end
		if (bins_y_q == 9'd0) begin
			by32 = 32'd1;
		end else if ({23'd0, bins_y_q} > 32'(MAX_BINS_Y)) begin
			by32 = 32'(MAX_BINS_Y);
		end else begin
			by32 = {23'd0, bins_y_q};
		end
		nx = bx32[NXW-1:0];
		ny = by32[NYW-1:0];
	end

	// controller
	state_t          state_q, state_nx;
	cmd_item_t       item_q;
	logic [AW-1:0]   clr_q;
	logic            clr_last;
	logic            accept, upd_go, mem_we;
	logic [XW-1:0]   xi_q;
	logic [YW-1:0]   yi_q;
	logic            oor_q;
	logic [AW-1:0]   addr_q;
	logic            beyond_q;
	logic [CB-1:0]   rd_q;
	logic [31:0]     lost_q;
	logic            res_valid_q;
	res_item_t       res_q;

	assign clr_last = (32'(clr_q) == 32'(DEPTH - 1));
	assign accept   = cmd_valid && !cmd_stall;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_last) state_nx = ST_IDLE;
			ST_IDLE:   if (cmd_valid) state_nx = ST_RANGE;
			ST_RANGE:  state_nx = ST_ADDR;
			ST_ADDR:   state_nx = ST_READ;
			ST_READ:   state_nx = ST_UPDATE;
			ST_UPDATE: if (!res_valid_q || !res_stall) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	logic [CB-1:0] limit;
	logic          is_full;
	logic          sample_hit;

	assign limit      = CB'(mode_limit(count_mode_q));
	assign is_full    = (rd_q >= limit);
	assign sample_hit = (item_q.command == CMD_SAMPLE) && !oor_q;

	always_comb begin
		cmd_stall = 1'b1;
		upd_go    = 1'b0;
		mem_we    = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				cmd_stall = 1'b0;
			end
			ST_UPDATE: begin
				upd_go = !res_valid_q || !res_stall;
				mem_we = upd_go && sample_hit && !is_full;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			lost_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (upd_go) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (upd_go && sample_hit && is_full && lost_q != 32'hFFFF_FFFF) begin
				lost_q <= lost_q + 32'd1;
			end
		end
	end

	// datapath
	logic signed [32:0] xi, yi;
	logic               x_in, y_in;
	logic [PW-1:0]      prod;
	logic [CB-1:0]      new_cnt;

	assign xi   = $signed({item_q.x_value[31], item_q.x_value})
	              - $signed({origin_x_q[31], origin_x_q});
	assign yi   = $signed({item_q.y_value[31], item_q.y_value})
	              - $signed({origin_y_q[31], origin_y_q});
	assign x_in = (xi >= 0) && (xi < $signed(33'(nx)));
	assign y_in = (yi >= 0) && (yi < $signed(33'(ny)));
	assign prod = PW'(nx) * PW'(yi_q) + PW'(xi_q);
	assign new_cnt = rd_q + CB'(1);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= cmd;
		end
		if (state_q == ST_RANGE) begin
			xi_q  <= xi[XW-1:0];
			yi_q  <= yi[YW-1:0];
			oor_q <= !(x_in && y_in);
		end
		if (state_q == ST_ADDR) begin
			if (item_q.command == CMD_READ) begin
				addr_q   <= AW'({16'd0, item_q.read_index});
				beyond_q <= ({16'd0, item_q.read_index} >= 32'(DEPTH));
			end else begin
				addr_q   <= prod[AW-1:0];
				beyond_q <= 1'b0;
			end
		end
		if (upd_go) begin
			res_q.counted      <= sample_hit && !is_full;
			res_q.out_of_range <= (item_q.command == CMD_SAMPLE) && oor_q;
			res_q.bin_full     <= sample_hit && is_full;
			if (lost_q != 32'hFFFF_FFFF && sample_hit && is_full) begin
				res_q.lost_total <= lost_q + 32'd1;
			end else begin
				res_q.lost_total <= lost_q;
			end
			if (item_q.command == CMD_READ) begin
				res_q.bin_count <= beyond_q ? 32'd0 : 32'(rd_q);
			end else if (oor_q) begin
				res_q.bin_count <= 32'd0;
			end else if (is_full) begin
				res_q.bin_count <= 32'(rd_q);
			end else begin
				res_q.bin_count <= 32'(new_cnt);
			end
		end
	end

	// bin store
	logic [CB-1:0] bins_mem [DEPTH];
	logic [AW-1:0] waddr;
	logic [CB-1:0] wdata;

	assign waddr = (state_q == ST_CLEAR) ? clr_q : addr_q;
	assign wdata = (state_q == ST_CLEAR) ? '0 : new_cnt;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= bins_mem[addr_q];
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ===== sim/tb_saturating_2d_histogram.sv =====
// Testbench for saturating_2d_histogram: directed rows, then randomized sample/read
// phases, checked against an in-bench histogram predictor or typed-in results. Depends on s2dh_pkg.
`timescale 1ns / 1ps

module tb_saturating_2d_histogram;
	import s2dh_pkg::*;

	localparam int CLK_HALF        = 5;
	localparam int GRID_X          = DEF_MAX_BINS_X;
	localparam int GRID_Y          = DEF_MAX_BINS_Y;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT  = 262144;
	localparam int REPORT_LIMIT    = 10;

	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_CHECKED,
		ROW_REG
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  reg_sel;
		logic [31:0] reg_val;
		cmd_item_t   item;
		res_item_t   lit;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cmd_valid;
	logic                  cmd_stall;
	cmd_item_t             cmd;
	logic                  res_valid;
	logic                  res_stall;
	res_item_t             res;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	// predictor state and register copies
	bit [31:0]          bin_tally [0:GRID_X*GRID_Y-1];
	logic [31:0]        lost_tally = '0;
	logic signed [31:0] org_x      = '0;
	logic signed [31:0] org_y      = '0;
	logic [8:0]         nbins_x    = 9'd256;
	logic [8:0]         nbins_y    = 9'd256;
	logic [1:0]         cnt_mode   = MODE_FULL;

	res_item_t bin_reports_due [$];
	dir_row_t  dir_rows [$];
	int        err_count     = 0;
	int        quiet_cycles  = 0;
	int        hold_off_req  = 0;
	bit        tx_calm       = 1'b0;
	bit        rx_calm       = 1'b0;

	saturating_2d_histogram i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #CLK_HALF clk = ~clk;

	function automatic longint grid_span(logic [8:0] v, int cap);
		longint n;
		n = longint'(v);
		if (n == 0)
			return 1;
		return (n > longint'(cap)) ? longint'(cap) : n;
	endfunction

	function automatic res_item_t histogram_step(cmd_item_t c);
		res_item_t   r;
		longint      xo, yo, nx, ny;
		int unsigned slot;
		logic [31:0] limit;
		r = '0;
		if (c.command == CMD_SAMPLE) begin
			xo = longint'($signed(c.x_value)) - longint'(org_x);
			yo = longint'($signed(c.y_value)) - longint'(org_y);
			nx = grid_span(nbins_x, GRID_X);
			ny = grid_span(nbins_y, GRID_Y);
			if (xo < 0 || xo >= nx || yo < 0 || yo >= ny) begin
				r.out_of_range = 1'b1;
			end else begin
				slot = 32'(nx * yo + xo);
				case (cnt_mode)
					MODE_8BIT:  limit = 32'd255;
					MODE_16BIT: limit = 32'd65535;
					default:    limit = 32'hFFFF_FFFF;
				endcase
				if (bin_tally[slot] >= limit) begin
					r.bin_full = 1'b1;
					if (lost_tally != 32'hFFFF_FFFF)
						lost_tally = lost_tally + 1;
				end else begin
					bin_tally[slot] = bin_tally[slot] + 1;
					r.counted = 1'b1;
				end
				r.bin_count = bin_tally[slot];
			end
		end else begin
			r.bin_count = bin_tally[c.read_index];
		end
		r.lost_total = lost_tally;
		return r;
	endfunction

	function automatic cmd_item_t pick_item(bit hot);
		cmd_item_t   c;
		longint      nx, ny;
		int unsigned roll;
		c.command    = CMD_SAMPLE;
		c.x_value    = $urandom;
		c.y_value    = $urandom;
		c.read_index = 16'($urandom);
		nx = grid_span(nbins_x, GRID_X);
		ny = grid_span(nbins_y, GRID_Y);
		roll = $urandom_range(99);
		if (roll < (hot ? 5 : 20)) begin
			c.command = CMD_READ;
			if ($urandom_range(3) != 0)
				c.read_index = 16'($urandom_range(32'(nx * ny - 1), 0));
		end else if (roll < (hot ? 95 : 85)) begin
			c.x_value = org_x + $urandom_range(32'(nx - 1), 0);
			c.y_value = org_y + $urandom_range(32'(ny - 1), 0);
		end else if (roll < 95) begin
			// just outside one edge of the grid
			c.x_value = org_x + $urandom_range(32'(nx - 1), 0);
			c.y_value = org_y + $urandom_range(32'(ny - 1), 0);
			case ($urandom_range(3))
				0:       c.x_value = org_x - 1;
				1:       c.x_value = org_x + 32'(nx);
				2:       c.y_value = org_y - 1;
				default: c.y_value = org_y + 32'(ny);
			endcase
		end
		return c;
	endfunction

	function automatic int pick_gap();
		int unsigned roll;
		if (tx_calm)
			return 0;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		if (roll < 98)
			return $urandom_range(10, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic dir_row_t smp(logic [31:0] x, logic [31:0] y);
		dir_row_t r;
		r = '0;
		r.kind               = ROW_ITEM;
		r.item.command       = CMD_SAMPLE;
		r.item.x_value       = x;
		r.item.y_value       = y;
		r.item.read_index    = 16'h5AA5;
		return r;
	endfunction

	function automatic dir_row_t rd(logic [15:0] idx);
		dir_row_t r;
		r = '0;
		r.kind               = ROW_ITEM;
		r.item.command       = CMD_READ;
		r.item.x_value       = 32'hFFFF_FFFF;
		r.item.y_value       = 32'hFFFF_FFFF;
		r.item.read_index    = idx;
		return r;
	endfunction

	function automatic dir_row_t wr(logic [2:0] sel, logic [31:0] val);
		dir_row_t r;
		r = '0;
		r.kind    = ROW_REG;
		r.reg_sel = sel;
		r.reg_val = val;
		return r;
	endfunction

	// typed-in result; lost count is still zero everywhere these are used
	function automatic dir_row_t known(dir_row_t r, logic [31:0] bin, logic cnt, logic oor);
		r.kind             = ROW_CHECKED;
		r.lit.bin_count    = bin;
		r.lit.counted      = cnt;
		r.lit.out_of_range = oor;
		r.lit.bin_full     = 1'b0;
		r.lit.lost_total   = '0;
		return r;
	endfunction

	task automatic check_result(res_item_t got);
		res_item_t want;
		if (bin_reports_due.size() == 0) begin
			err_count++;
			if (err_count <= REPORT_LIMIT)
				$display("unexpected result: bin %0d cnt %b oor %b full %b lost %0d",
					got.bin_count, got.counted, got.out_of_range, got.bin_full,
					got.lost_total);
		end else begin
			want = bin_reports_due.pop_front();
			if (got.bin_count !== want.bin_count || got.counted !== want.counted ||
					got.out_of_range !== want.out_of_range ||
					got.bin_full !== want.bin_full || got.lost_total !== want.lost_total) begin
				err_count++;
				if (err_count <= REPORT_LIMIT)
					$display({"mismatch: expected bin %0d cnt %b oor %b full %b lost %0d,",
						" got bin %0d cnt %b oor %b full %b lost %0d"},
						want.bin_count, want.counted, want.out_of_range, want.bin_full,
						want.lost_total, got.bin_count, got.counted, got.out_of_range,
						got.bin_full, got.lost_total);
			end
		end
	endtask

	task automatic offer_item(cmd_item_t c, bit typed, res_item_t lit);
		res_item_t due;
		int        gap;
		cmd       <= c;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (cmd_stall);
		due = histogram_step(c);
		bin_reports_due.push_back(typed ? lit : due);
		gap = pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (bin_reports_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] sel, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (sel)
			REG_ORIGIN_X:   org_x    = val;
			REG_ORIGIN_Y:   org_y    = val;
			REG_BINS_X:     nbins_x  = val[8:0];
			REG_BINS_Y:     nbins_y  = val[8:0];
			REG_COUNT_MODE: cnt_mode = val[1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic run_phase(logic [31:0] ox, logic [31:0] oy, logic [31:0] bx,
			logic [31:0] by, logic [1:0] mode, int n, bit hot, bit calm_tx,
			bit calm_rx, int hold);
		settle();
		reg_write(REG_ORIGIN_X, ox);
		reg_write(REG_ORIGIN_Y, oy);
		reg_write(REG_BINS_X, bx);
		reg_write(REG_BINS_Y, by);
		reg_write(REG_COUNT_MODE, {30'd0, mode});
		tx_calm      = calm_tx;
		rx_calm      = calm_rx;
		hold_off_req = hold;
		repeat (n) offer_item(pick_item(hot), 1'b0, '0);
	endtask

	// result side: random stalls, long hold-off on request
	initial begin
		int          stall_left;
		int unsigned roll;
		stall_left = 0;
		res_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall)
				check_result(res);
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (hold_off_req > 0) begin
				stall_left   = hold_off_req - 1;
				hold_off_req = 0;
				res_stall <= 1'b1;
			end else if (rx_calm) begin
				res_stall <= 1'b0;
			end else begin
				roll = $urandom_range(99);
				if (roll < 70) begin
					res_stall <= 1'b0;
				end else if (roll < 95) begin
					stall_left = $urandom_range(2, 0);
					res_stall <= 1'b1;
				end else begin
					stall_left = $urandom_range(40, 10);
					res_stall <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", quiet_cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset grid: 256 x 256, origin 0, full-width bins
		dir_rows.push_back(known(rd(16'd0), 32'd0, 1'b0, 1'b0));
		dir_rows.push_back(known(rd(16'hFFFF), 32'd0, 1'b0, 1'b0));
		dir_rows.push_back(known(smp(32'd0, 32'd0), 32'd1, 1'b1, 1'b0));
		dir_rows.push_back(known(smp(32'd255, 32'd255), 32'd1, 1'b1, 1'b0));
		dir_rows.push_back(known(smp(32'd256, 32'd0), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'd0, 32'd256), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'hFFFF_FFFF, 32'd0), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'd0, 32'hFFFF_FFFF), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'h8000_0000, 32'h7FFF_FFFF), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'h7FFF_FFFF, 32'h8000_0000), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(rd(16'hFFFF), 32'd1, 1'b0, 1'b0));
		dir_rows.push_back(known(smp(32'd0, 32'd0), 32'd2, 1'b1, 1'b0));
		dir_rows.push_back(smp(32'd255, 32'd0));
		dir_rows.push_back(smp(32'd0, 32'd255));
		dir_rows.push_back(rd(16'd255));
		dir_rows.push_back(rd(16'hFF00));
		// extreme origins, zero bin counts act as a single bin
		dir_rows.push_back(wr(REG_ORIGIN_X, 32'h8000_0000));
		dir_rows.push_back(wr(REG_ORIGIN_Y, 32'h7FFF_FFFF));
		dir_rows.push_back(wr(REG_BINS_X, 32'd0));
		dir_rows.push_back(wr(REG_BINS_Y, 32'd0));
		dir_rows.push_back(wr(REG_COUNT_MODE, {30'd0, MODE_8BIT}));
		dir_rows.push_back(smp(32'h8000_0000, 32'h7FFF_FFFF));
		dir_rows.push_back(known(smp(32'h8000_0001, 32'h7FFF_FFFF), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(known(smp(32'h7FFF_FFFF, 32'h8000_0000), 32'd0, 1'b0, 1'b1));
		// bin counts above the maximum clip to 256
		dir_rows.push_back(wr(REG_ORIGIN_X, 32'd0));
		dir_rows.push_back(wr(REG_ORIGIN_Y, 32'd0));
		dir_rows.push_back(wr(REG_BINS_X, 32'h1FF));
		dir_rows.push_back(wr(REG_BINS_Y, 32'h101));
		dir_rows.push_back(smp(32'd255, 32'd255));
		dir_rows.push_back(known(smp(32'd256, 32'd0), 32'd0, 1'b0, 1'b1));
		dir_rows.push_back(rd(16'd17));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				settle();
				reg_write(dir_rows[i].reg_sel, dir_rows[i].reg_val);
			end else begin
				offer_item(dir_rows[i].item, dir_rows[i].kind == ROW_CHECKED,
					dir_rows[i].lit);
			end
		end

		//        origin x        origin y        bins x  bins y  mode        items hot tx rx hold
		run_phase(32'hFFFF_FF9C, 32'd37,         32'd16,  32'd8,   MODE_FULL,  120, 0, 0, 1, 0);
		// one bin hammered until it saturates, raised past 255, then limit lowered
		run_phase(32'd0,         32'd0,          32'd0,   32'd1,   MODE_8BIT,  330, 1, 0, 0, 0);
		run_phase(32'd0,         32'd0,          32'd0,   32'd1,   MODE_16BIT,  60, 1, 1, 1, 0);
		run_phase(32'd0,         32'd0,          32'd0,   32'd1,   MODE_8BIT,   30, 1, 1, 0, 0);
		run_phase(32'h7FFF_FFD0, 32'h8000_0000,  32'd300, 32'd256, MODE_32BIT, 120, 0, 0, 0, 0);
		run_phase(32'h8000_0000, 32'h7FFF_FFFF,  32'd256, 32'd0,   MODE_FULL,   60, 0, 0, 0, 0);
		run_phase(32'd0,         32'd0,          32'd256, 32'd256, MODE_16BIT, 100, 0, 1, 0, 300);

		cmd_valid <= 1'b0;
		while (bin_reports_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && bin_reports_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
